### hdl/assert_macros.svh
// assertion macros used by the rtl top, cartesian_tree_builder.sv
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every enabled edge
`define CTB_CHECK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// condition must never be seen at an enabled edge
`define CTB_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define CTB_CHECK(lbl, clk, rst_n, prop, msg)
`define CTB_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### hdl/ctb_pkg.sv
// shared types and constants of the cartesian tree builder
// no dependencies
package ctb_pkg;

    localparam int NW            = 11;   // index field width
    localparam int SW            = 21;   // checksum width
    localparam int VW            = 32;   // key width
    localparam int KW            = 2;    // kind field width
    localparam int MAX_NODES_DEF = 1024;

    typedef enum logic [KW-1:0] {
        K_APPEND = 2'd0,
        K_QUERY  = 2'd1,
        K_CLEAR  = 2'd2,
        K_NOP    = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_LINK,
        S_SUM_NEW,
        S_SUM_OLD,
        S_SUM_TOP,
        S_QRD,
        S_FIN
    } t_state;

    // multiplier operand selection
    typedef enum logic [1:0] {
        MS_NEW_LEFT,
        MS_TOP_OLD,
        MS_TOP_NEW
    } t_msel;

    typedef struct packed {
        logic  latch;
        logic  pop;
        logic  resolve;
        logic  wr_node;
        logic  wr_top;
        logic  acc_new;
        logic  acc_top;
        logic  commit;
        logic  q_read;
        logic  load_out;
        t_msel msel;
    } t_cmd;

    typedef struct packed {
        logic d_nz;
        logic greater;
        logic full;
        logic out_free;
    } t_stat;

endpackage

### hdl/ctb_ctrl.sv
// sequencer of the cartesian tree builder
// depends on ctb_pkg
module ctb_ctrl import ctb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_kind i_kind,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.msel = MS_NEW_LEFT;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    unique case (i_kind)
                        K_APPEND: n_state = i_stat.full ? S_FIN : S_POP;
                        K_QUERY:  n_state = S_QRD;
                        default:  n_state = S_FIN;
                    endcase
                end
            end
            S_POP: begin
                if (i_stat.d_nz && i_stat.greater) begin
                    o_cmd.pop = 1'b1;
                end else begin
                    o_cmd.resolve = 1'b1;
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                o_cmd.wr_node = 1'b1;
                o_cmd.msel    = MS_NEW_LEFT;
                n_state       = S_SUM_NEW;
            end
            S_SUM_NEW: begin
                o_cmd.acc_new = 1'b1;
                o_cmd.wr_top  = 1'b1;
                o_cmd.msel    = MS_TOP_OLD;
                n_state       = S_SUM_OLD;
            end
            S_SUM_OLD: begin
                o_cmd.acc_top = 1'b1;
                o_cmd.msel    = MS_TOP_NEW;
                n_state       = S_SUM_TOP;
            end
            S_SUM_TOP: begin
                o_cmd.acc_top = 1'b1;
                o_cmd.commit  = 1'b1;
                n_state       = S_FIN;
            end
            S_QRD: begin
                o_cmd.q_read = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

### hdl/ctb_dp.sv
// datapath of the cartesian tree builder: stack and link memories,
// checksum multiplier, tree registers and output register; depends on ctb_pkg
module ctb_dp import ctb_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_kind                i_kind,
    input  logic signed [VW-1:0] i_value,
    input  logic [NW-1:0]        i_node,
    input  logic                 i_out_stall,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic                 o_out_valid,
    output logic [NW-1:0]        o_assigned_index,
    output logic [NW-1:0]        o_left_child,
    output logic [NW-1:0]        o_right_child,
    output logic [NW-1:0]        o_root_index,
    output logic [SW-1:0]        o_left_checksum,
    output logic [SW-1:0]        o_right_checksum,
    output logic                 o_full_res
);

    localparam int IW = $clog2(MAX_NODES + 1);
    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int OW = IW + 1;
    localparam int PW = 2 * OW;
    localparam int CW = (IW > NW) ? IW : NW;

    // stack entry: {node index, key}
    logic [IW+VW-1:0] stk_mem [MAX_NODES];
    logic [IW-1:0]    lft_mem [MAX_NODES];
    logic [IW-1:0]    rgt_mem [MAX_NODES];

    logic [IW+VW-1:0] r_stk_q;
    logic [IW-1:0]    r_lft_q, r_rgt_q;

    // tree state
    logic [IW-1:0] r_depth, r_count, r_root;
    logic [SW-1:0] r_lsum, r_rsum;

    // per item work registers
    t_kind                r_kind;
    logic signed [VW-1:0] r_val;
    logic [NW-1:0]        r_node;
    logic                 r_full;
    logic [IW-1:0]        r_d, n_d, r_idx, r_last, r_top;
    logic                 r_has_top;
    logic [SW-1:0]        r_prod;

    logic                 r_ovalid;

    logic [IW-1:0]        w_stk_idx;
    logic signed [VW-1:0] w_stk_val;
    logic [OW-1:0]        w_ma, w_mb;
    logic [PW-1:0]        w_prod;
    logic                 w_rw_we;
    logic [AW-1:0]        w_rw_addr;
    logic [IW-1:0]        w_rw_data;
    logic                 w_qok;

    assign w_stk_idx = r_stk_q[IW+VW-1:VW];
    assign w_stk_val = r_stk_q[VW-1:0];

    always_comb begin
        n_d = r_d;
        if (i_cmd.latch) begin
            n_d = r_depth;
        end else if (i_cmd.pop) begin
            n_d = r_d - IW'(1);
        end
    end

    // stack: read entry below the next depth every cycle
    always_ff @(posedge i_clk) begin
        r_stk_q <= stk_mem[AW'(n_d - IW'(1))];
        if (i_cmd.wr_node) begin
            stk_mem[AW'(r_d)] <= {r_idx, r_val};
        end
    end

    // link memories, node n lives at address n-1
    assign w_rw_we   = i_cmd.wr_node || (i_cmd.wr_top && r_has_top);
    assign w_rw_addr = i_cmd.wr_node ? AW'(r_idx - IW'(1)) : AW'(r_top - IW'(1));
    assign w_rw_data = i_cmd.wr_node ? '0 : r_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_node) begin
            lft_mem[AW'(r_idx - IW'(1))] <= r_last;
        end
        if (i_cmd.q_read) begin
            r_lft_q <= lft_mem[AW'(r_node - NW'(1))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rw_we) begin
            rgt_mem[w_rw_addr] <= w_rw_data;
        end
        if (i_cmd.q_read) begin
            r_rgt_q <= rgt_mem[AW'(r_node - NW'(1))];
        end
    end

    // shared checksum multiplier
    always_comb begin
        unique case (i_cmd.msel)
            MS_TOP_OLD: begin
                w_ma = OW'(r_top);
                w_mb = OW'(r_last) + OW'(1);
            end
            MS_TOP_NEW: begin
                w_ma = OW'(r_top);
                w_mb = OW'(r_idx) + OW'(1);
            end
            default: begin
                w_ma = OW'(r_idx);
                w_mb = OW'(r_last) + OW'(1);
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_qok  = (r_node != '0) && (CW'(r_node) <= CW'(r_count));

    // item registers, no reset
    always_ff @(posedge i_clk) begin
        r_prod <= SW'(w_prod);
        r_d    <= n_d;
        if (i_cmd.latch) begin
            r_kind    <= i_kind;
            r_val     <= i_value;
            r_node    <= i_node;
            r_full    <= (i_kind == K_APPEND) && (r_count == IW'(MAX_NODES));
            r_idx     <= r_count + IW'(1);
            r_last    <= '0;
            r_has_top <= 1'b0;
        end
        if (i_cmd.pop) begin
            r_last <= w_stk_idx;
        end
        if (i_cmd.resolve) begin
            r_top     <= w_stk_idx;
            r_has_top <= (r_d != '0);
        end
        if (i_cmd.load_out) begin
            o_assigned_index <= (r_kind == K_APPEND && !r_full) ? NW'(r_idx) : '0;
            o_left_child     <= (r_kind == K_QUERY && w_qok) ? NW'(r_lft_q) : '0;
            o_right_child    <= (r_kind == K_QUERY && w_qok) ? NW'(r_rgt_q) : '0;
            o_root_index     <= (r_kind == K_CLEAR) ? '0 : NW'(r_root);
            o_left_checksum  <= (r_kind == K_CLEAR) ? '0 : r_lsum;
            o_right_checksum <= (r_kind == K_CLEAR) ? '0 : r_rsum;
            o_full_res       <= r_full;
        end
    end

    // tree state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= '0;
            r_count  <= '0;
            r_root   <= '0;
            r_lsum   <= '0;
            r_rsum   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.acc_new) begin
                r_lsum <= r_lsum ^ r_prod;
                r_rsum <= r_rsum ^ SW'(r_idx);
            end
            if (i_cmd.acc_top && r_has_top) begin
                r_rsum <= r_rsum ^ r_prod;
            end
            if (i_cmd.commit) begin
                r_depth <= r_d + IW'(1);
                r_count <= r_idx;
                if (!r_has_top) begin
                    r_root <= r_idx;
                end
            end
            if (i_cmd.load_out && r_kind == K_CLEAR) begin
                r_depth <= '0;
                r_count <= '0;
                r_root  <= '0;
                r_lsum  <= '0;
                r_rsum  <= '0;
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_stat.d_nz     = (r_d != '0);
    assign o_stat.greater  = (w_stk_val > r_val);
    assign o_stat.full     = (r_count == IW'(MAX_NODES));
    assign o_stat.out_free = !r_ovalid || !i_out_stall;

endmodule

### hdl/cartesian_tree_builder.sv
// Cartesian tree builder, min at the root, built online with a monotonic stack.
// Items are one at a time. An append first pops the stack entries with greater keys:
// the stack memory delivers one entry per cycle, then the states LINK, SUM_NEW,
// SUM_OLD and SUM_TOP share one multiplier for the checksum terms and write the
// links, and a last state loads the output register. Pops are bounded by earlier
// pushes. Queries make one link memory read before the output load; clears and
// unused kinds go straight to it. A finished item waits in the output register;
// the next item is taken once that result has been loaded there.
// Appends beyond MAX_NODES nodes are refused with o_full_res set.
// depends on ctb_pkg, ctb_ctrl, ctb_dp and assert_macros.svh
`include "assert_macros.svh"

module cartesian_tree_builder import ctb_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input item channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [KW-1:0]        i_kind,
    input  logic signed [VW-1:0] i_value,
    input  logic [NW-1:0]        i_node,
    // result item channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [NW-1:0]        o_assigned_index,
    output logic [NW-1:0]        o_left_child,
    output logic [NW-1:0]        o_right_child,
    output logic [NW-1:0]        o_root_index,
    output logic [SW-1:0]        o_left_checksum,
    output logic [SW-1:0]        o_right_checksum,
    output logic                 o_full_res
);

    t_cmd  cmd;
    t_stat stat;
    t_kind w_kind;

    assign w_kind = t_kind'(i_kind);

    // sequencer: stack walk, checksum steps, query read, output load
    ctb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (w_kind),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // memories, tree registers and the output register
    ctb_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_kind           (w_kind),
        .i_value          (i_value),
        .i_node           (i_node),
        .i_out_stall      (i_out_stall),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .o_assigned_index (o_assigned_index),
        .o_left_child     (o_left_child),
        .o_right_child    (o_right_child),
        .o_root_index     (o_root_index),
        .o_left_checksum  (o_left_checksum),
        .o_right_checksum (o_right_checksum),
        .o_full_res       (o_full_res)
    );

    // a refused append reports no index and no children
    `CTB_CHECK(a_full_clean, i_clk, i_rst_n, (o_out_valid && o_full_res) |-> (o_assigned_index == '0 && o_left_child == '0 && o_right_child == '0), "refused append carries index or children")
    // a result is only loaded when the output register can take it
    `CTB_CHECK(a_load_free, i_clk, i_rst_n, cmd.load_out |-> stat.out_free, "result loaded over a waiting result")
    // the block stays busy while it walks the stack
    `CTB_CHECK(a_pop_busy, i_clk, i_rst_n, cmd.pop |=> o_in_stall, "input taken during stack walk")

endmodule

### tb/tb_cartesian_tree_builder.sv
// self-checking testbench for the cartesian tree builder: directed edges, capacity fill, random
// appends/queries/clears under three idling mixes, checked against an in-bench tree predictor
// depends on ctb_pkg and the cartesian_tree_builder rtl
module tb_cartesian_tree_builder import ctb_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = MAX_NODES_DEF;

    // one result item as the block reports it
    typedef struct packed {
        logic [NW-1:0] assigned_index;
        logic [NW-1:0] left_child;
        logic [NW-1:0] right_child;
        logic [NW-1:0] root_index;
        logic [SW-1:0] left_checksum;
        logic [SW-1:0] right_checksum;
        logic          full_res;
    } t_tree_result;

    // value styles for random appends
    typedef enum int {
        KEYS_WIDE,
        KEYS_NARROW,
        KEYS_RISING,
        KEYS_FALLING,
        KEYS_EXTREME
    } t_key_style;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [KW-1:0]        i_kind = K_NOP;
    logic signed [VW-1:0] i_value = '0;
    logic [NW-1:0]        i_node = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [NW-1:0]        o_assigned_index;
    logic [NW-1:0]        o_left_child;
    logic [NW-1:0]        o_right_child;
    logic [NW-1:0]        o_root_index;
    logic [SW-1:0]        o_left_checksum;
    logic [SW-1:0]        o_right_checksum;
    logic                 o_full_res;

    // predicted tree: monotonic stack plus child links per node, 1-based
    int                   stack_node [CAPACITY];
    logic signed [VW-1:0] stack_key [CAPACITY];
    int                   left_of [CAPACITY+1];
    int                   right_of [CAPACITY+1];
    int                   stack_depth;
    int                   tree_size;
    int                   root_node;
    logic [SW-1:0]        left_sum;
    logic [SW-1:0]        right_sum;

    // results still owed by the block, oldest first
    t_tree_result         pending_results [$];

    // idling percentages for the two sides
    int                   send_idle_pct;
    int                   recv_idle_pct;

    // random key generator state
    t_key_style           key_style;
    logic signed [VW-1:0] last_key;

    // bookkeeping for the summary
    int                   mismatch_count;
    int                   results_checked;
    int                   append_count;
    int                   refused_count;
    int                   query_count;
    int                   clear_count;
    int                   nop_count;
    int                   deepest_stack;

    cartesian_tree_builder #(
        .MAX_NODES(CAPACITY)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_value         (i_value),
        .i_node          (i_node),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_assigned_index(o_assigned_index),
        .o_left_child    (o_left_child),
        .o_right_child   (o_right_child),
        .o_root_index    (o_root_index),
        .o_left_checksum (o_left_checksum),
        .o_right_checksum(o_right_checksum),
        .o_full_res      (o_full_res)
    );

    always #1 i_clk = ~i_clk;

    // hard stop if the block hangs
    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    // checksum contribution of one node: index times (child + 1), wrapped to the sum width
    function automatic logic [SW-1:0] child_term(input int idx, input int child);
        return SW'(idx * (child + 1));
    endfunction

    // advance the predicted tree by one item and return the result it must produce
    function automatic void tree_predict(input t_kind kind, input logic signed [VW-1:0] value,
                                         input logic [NW-1:0] node, output t_tree_result res);
        int d;
        int idx;
        int last;
        int top;
        res = '0;
        case (kind)
            K_APPEND: begin
                append_count++;
                if (tree_size >= CAPACITY) begin
                    // tree full: nothing changes, the refusal is flagged
                    res.full_res = 1'b1;
                    refused_count++;
                end else begin
                    idx = tree_size + 1;
                    d = stack_depth;
                    last = 0;
                    // pop strictly greater keys, the last one popped becomes the left child
                    while (d > 0 && stack_key[d-1] > value) begin
                        last = stack_node[d-1];
                        d--;
                    end
                    left_of[idx] = last;
                    right_of[idx] = 0;
                    left_sum ^= child_term(idx, last);
                    right_sum ^= child_term(idx, 0);
                    if (d > 0) begin
                        // new node hangs off the remaining top as its right child
                        top = stack_node[d-1];
                        right_sum ^= child_term(top, right_of[top]) ^ child_term(top, idx);
                        right_of[top] = idx;
                    end else begin
                        root_node = idx;
                    end
                    stack_node[d] = idx;
                    stack_key[d] = value;
                    stack_depth = d + 1;
                    tree_size = idx;
                    res.assigned_index = NW'(idx);
                    if (stack_depth > deepest_stack) deepest_stack = stack_depth;
                end
            end
            K_QUERY: begin
                query_count++;
                // node 0 or beyond the last node reads back as no children
                if (node >= 1 && node <= tree_size) begin
                    res.left_child = NW'(left_of[node]);
                    res.right_child = NW'(right_of[node]);
                end
            end
            K_CLEAR: begin
                clear_count++;
                stack_depth = 0;
                tree_size = 0;
                root_node = 0;
                left_sum = '0;
                right_sum = '0;
            end
            default: begin
                nop_count++;
            end
        endcase
        res.root_index = NW'(root_node);
        res.left_checksum = left_sum;
        res.right_checksum = right_sum;
    endfunction

    // present one item, hold it through stalls, predict once it is taken
    task automatic send_item(input t_kind kind, input logic [VW-1:0] value,
                             input logic [NW-1:0] node);
        t_tree_result want;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_value <= value;
        i_node <= node;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tree_predict(kind, $signed(value), node, want);
        pending_results.push_back(want);
    endtask

    // sender goes quiet until every owed result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // next key for a random append, shaped by the current style
    function automatic logic [VW-1:0] next_key();
        case (key_style)
            KEYS_WIDE:    last_key = $urandom;
            KEYS_NARROW:  last_key = $signed($urandom_range(0, 8)) - 4;
            KEYS_RISING:  last_key = last_key + $signed($urandom_range(0, 3));
            KEYS_FALLING: last_key = last_key - $signed($urandom_range(0, 3));
            default: begin
                case ($urandom_range(0, 3))
                    0: last_key = 32'sh7FFF_FFFF;
                    1: last_key = 32'sh8000_0000;
                    2: last_key = '0;
                    default: last_key = -1;
                endcase
            end
        endcase
        return last_key;
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on %s: expected %0d, got %0d (result %0d)",
                         name, want, got, results_checked);
        end
    endfunction

    // result side: random stall, compare each taken item with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_tree_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result item with nothing owed: assigned %0d root %0d",
                             o_assigned_index, o_root_index);
            end else begin
                want = pending_results.pop_front();
                compare_field("assigned_index", 32'(want.assigned_index),
                              32'(o_assigned_index));
                compare_field("left_child", 32'(want.left_child), 32'(o_left_child));
                compare_field("right_child", 32'(want.right_child), 32'(o_right_child));
                compare_field("root_index", 32'(want.root_index), 32'(o_root_index));
                compare_field("left_checksum", 32'(want.left_checksum),
                              32'(o_left_checksum));
                compare_field("right_checksum", 32'(want.right_checksum),
                              32'(o_right_checksum));
                compare_field("full_res", 32'(want.full_res), 32'(o_full_res));
                results_checked++;
            end
        end
    end

    // extremes of the key, equal keys, pops to empty, bad query indices, unused kind, clear
    task automatic test_edges();
        send_item(K_QUERY, $urandom, 11'd0);
        send_item(K_QUERY, $urandom, 11'd1);
        send_item(K_NOP, $urandom, NW'($urandom_range(0, 2047)));
        send_item(K_APPEND, 32'h7FFF_FFFF, 11'd0);
        send_item(K_APPEND, 32'h7FFF_FFFF, 11'd2047);
        send_item(K_APPEND, 32'h8000_0000, 11'd0);
        send_item(K_APPEND, 32'h0000_0000, 11'd0);
        send_item(K_APPEND, 32'hFFFF_FFFF, 11'd0);
        send_item(K_APPEND, 32'hFFFF_FFFF, 11'd0);
        for (int n = 0; n <= 7; n++) send_item(K_QUERY, $urandom, NW'(n));
        send_item(K_QUERY, 32'hFFFF_FFFF, 11'd2047);
        send_item(K_QUERY, 32'h0, 11'd1024);
        send_item(K_NOP, 32'h0, 11'd0);
        send_item(K_CLEAR, $urandom, NW'($urandom_range(0, 2047)));
        send_item(K_QUERY, $urandom, 11'd1);
        send_item(K_APPEND, 32'd5, 11'd0);
        send_item(K_QUERY, $urandom, 11'd1);
        send_item(K_CLEAR, 32'h0, 11'd0);
    endtask

    // fill to one below capacity with rising keys, then one key that pops the whole stack
    // and fills it, then refused appends and queries before, at and past the last node
    task automatic test_capacity();
        send_item(K_CLEAR, 32'h0, 11'd0);
        for (int n = 1; n < CAPACITY; n++)
            send_item(K_APPEND, 32'(n * 1000 - 500000), NW'($urandom_range(0, 2047)));
        send_item(K_APPEND, 32'h8000_0000, 11'd0);
        send_item(K_APPEND, $urandom, 11'd0);
        send_item(K_APPEND, 32'h8000_0000, 11'd0);
        send_item(K_QUERY, $urandom, NW'(CAPACITY));
        send_item(K_QUERY, $urandom, NW'(CAPACITY + 1));
        send_item(K_QUERY, $urandom, NW'(CAPACITY - 1));
        // hold off until the block has returned everything
        drain_results();
        send_item(K_CLEAR, 32'h0, 11'd0);
    endtask

    // mostly append runs and queries of live nodes, with a sprinkle of noise and clears
    task automatic test_random(input int items);
        int pick;
        logic [NW-1:0] node;
        for (int i = 0; i < items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 63) begin
                if ($urandom_range(0, 99) < 8) key_style = t_key_style'($urandom_range(0, 4));
                send_item(K_APPEND, next_key(), NW'($urandom_range(0, 2047)));
            end else if (pick < 93) begin
                if (tree_size > 0 && $urandom_range(0, 99) < 80)
                    node = NW'($urandom_range(1, tree_size));
                else
                    node = NW'($urandom_range(0, 2047));
                send_item(K_QUERY, $urandom, node);
            end else if (pick < 96) begin
                send_item(K_CLEAR, $urandom, NW'($urandom_range(0, 2047)));
            end else begin
                send_item(K_NOP, $urandom, NW'($urandom_range(0, 2047)));
            end
        end
    endtask

    initial begin
        stack_depth = 0;
        tree_size = 0;
        root_node = 0;
        left_sum = '0;
        right_sum = '0;
        key_style = KEYS_NARROW;
        last_key = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender mostly busy, receiver mostly stalled
        send_idle_pct = 7;
        recv_idle_pct = 74;
        test_edges();
        test_random(230);

        // the other way round
        send_idle_pct = 74;
        recv_idle_pct = 7;
        test_capacity();
        test_random(230);

        // full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(240);

        drain_results();
        repeat (16) @(posedge i_clk);

        $display("covered %0d appends (%0d refused), %0d queries, %0d clears, %0d unused kinds",
                 append_count, refused_count, query_count, clear_count, nop_count);
        $display("checked %0d results, deepest stack %0d, %0d results missing",
                 results_checked, deepest_stack, pending_results.size());
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/ctb_pkg.sv
hdl/ctb_ctrl.sv
hdl/ctb_dp.sv
hdl/cartesian_tree_builder.sv
tb/tb_cartesian_tree_builder.sv
